// ===== sv/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants for the byte stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

	// Stack operation codes carried on the opcode field
	typedef enum logic [3:0] {
		OP_PUSH = 4'd0,
		OP_POP  = 4'd1,
		OP_PEEK = 4'd2,
		OP_DROP = 4'd3,
		OP_SWAP = 4'd4,
		OP_OVER = 4'd5,
		OP_ROT  = 4'd6,
		OP_ROLL = 4'd7,
		OP_PICK = 4'd8
	} opcode_t;

	// What every cell of the chain does on each clock
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_PUSH = 2'd1, // take the value of the cell above (toward the top)
		CELL_POP  = 2'd2, // take the value of the cell below
		CELL_ROLL = 2'd3  // cells above roll_end take below, roll_end takes top
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [7:0]  push_data;
		logic        rd_en;
	} cell_cmd_t;

	// Cells per group in the registered read tree
	localparam int GRP = 16;

endpackage

`default_nettype wire

// ===== sv/bse_cell.sv =====
// ----------------------------------------------------------------------------
// bse_cell
// One stack slot: a byte register fed by its neighbors and the top cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_cell #(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bse_pkg::cell_op_t op,
	input  wire logic [IW-1:0]   roll_end,
	input  wire logic [IW-1:0]   sel,
	input  wire logic            rd_en,
	input  wire logic [7:0]      prev_val,
	input  wire logic [7:0]      next_val,
	input  wire logic [7:0]      top_val,
	output logic [7:0]           val,
	output logic [7:0]           rd_val
);
	import bse_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [7:0] val_q;
	logic [7:0] val_nxt;

	always_comb begin
		val_nxt = val_q;
		case (op)
			CELL_PUSH: val_nxt = prev_val;
			CELL_POP:  val_nxt = next_val;
			CELL_ROLL: begin
				if (MY_IDX < roll_end)
					val_nxt = next_val;
				else if (MY_IDX == roll_end)
					val_nxt = top_val;
			end
			default:   val_nxt = val_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			val_q <= '0;
		else
			val_q <= val_nxt;
	end

	assign val    = val_q;
	assign rd_val = (rd_en && (sel == MY_IDX)) ? val_q : 8'd0;

endmodule

`default_nettype wire

// ===== sv/bse_decode.sv =====
// ----------------------------------------------------------------------------
// bse_decode
// Turns one opcode and the current depth into a command for the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_decode #(
	parameter int CAPACITY = 64,
	parameter int IW       = 6,
	parameter int DW       = 7
) (
	input  wire logic [3:0]        opcode,
	input  wire logic [7:0]        push_value,
	input  wire logic [7:0]        position,
	input  wire logic [DW-1:0]     depth,
	input  wire logic [7:0]        second,
	output bse_pkg::cell_cmd_t     cmd,
	output logic [IW-1:0]          roll_end,
	output logic [IW-1:0]          sel,
	output logic [DW-1:0]          depth_nxt,
	output logic                   ovf
);
	import bse_pkg::*;

	localparam int CW = (DW > 8) ? DW : 8;
	localparam logic [DW-1:0] CAP = DW'(CAPACITY);

	logic          full;
	logic [CW-1:0] pos_x;
	logic [CW-1:0] d_x;
	logic [CW-1:0] pos_m1;
	logic [DW-1:0] d_inc;
	logic [DW-1:0] d_dec;

	assign full   = (depth == CAP);
	assign pos_x  = CW'(position);
	assign d_x    = CW'(depth);
	assign pos_m1 = pos_x - CW'(1);
	assign d_inc  = depth + DW'(1);
	assign d_dec  = depth - DW'(1);

	always_comb begin
		cmd.op        = CELL_HOLD;
		cmd.push_data = 8'd0;
		cmd.rd_en     = 1'b0;
		roll_end      = '0;
		sel           = '0;
		depth_nxt     = depth;
		ovf           = 1'b0;
		case (opcode_t'(opcode))
			OP_PUSH: begin
				if (full) begin
					ovf = 1'b1;
				end else begin
					cmd.op        = CELL_PUSH;
					cmd.push_data = push_value;
					depth_nxt     = d_inc;
				end
			end
			OP_POP, OP_DROP: begin
				cmd.rd_en = (opcode_t'(opcode) == OP_POP);
				if (depth != '0) begin
					cmd.op    = CELL_POP;
					depth_nxt = d_dec;
				end
			end
			OP_PEEK: begin
				// empty stack: cell 0 holds zero
				cmd.rd_en = 1'b1;
			end
			OP_SWAP: begin
				if (depth >= DW'(2)) begin
					cmd.op   = CELL_ROLL;
					roll_end = IW'(1);
				end
			end
			OP_OVER: begin
				if (depth >= DW'(2)) begin
					if (full) begin
						ovf = 1'b1;
					end else begin
						cmd.op        = CELL_PUSH;
						cmd.push_data = second;
						depth_nxt     = d_inc;
					end
				end
			end
			OP_ROT: begin
				if (depth >= DW'(3)) begin
					cmd.op   = CELL_ROLL;
					roll_end = IW'(2);
				end
			end
			OP_ROLL: begin
				if (pos_x > d_x) begin
					// roll past the bottom pushes a zero
					if (full) begin
						ovf = 1'b1;
					end else begin
						cmd.op    = CELL_PUSH;
						depth_nxt = d_inc;
					end
				end else if (pos_x >= CW'(2)) begin
					cmd.op   = CELL_ROLL;
					roll_end = pos_m1[IW-1:0];
				end
			end
			OP_PICK: begin
				// cells below the depth are zero, so an empty stack reads 0
				cmd.rd_en = 1'b1;
				if (pos_x >= d_x)
					sel = d_dec[IW-1:0];
				else
					sel = position[IW-1:0] & {IW{1'b1}};
			end
			default: begin
				cmd.op = CELL_HOLD;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/byte_stack_engine_top.sv =====
// ----------------------------------------------------------------------------
// byte_stack_engine_top
// Byte stack for a stack-language machine built as a chain of cells.
// ----------------------------------------------------------------------------
// The stack is a row of CAPACITY byte cells, cell 0 holding the top item;
// every operation (push, pop, peek, drop, swap, over, rot, roll, pick) is a
// read or one shift or partial rotate of the chain and completes in the
// cycle its beat is accepted, so the block takes one beat per cycle unless
// in_stall is high. Each beat yields one result beat: the read value goes
// through a registered OR tree over groups of 16 cells, then the output
// register. Reads of empty slots return 0 because freed cells are cleared.
`default_nettype none

module byte_stack_engine_top #(
	parameter int CAPACITY = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [3:0] opcode,
	input  wire logic [7:0] push_value,
	input  wire logic [7:0] position,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_value,
	output logic [6:0]      depth,
	output logic            is_empty,
	output logic            overflowed
);
	import bse_pkg::*;

	localparam int IW   = $clog2(CAPACITY);
	localparam int DW   = $clog2(CAPACITY + 1);
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_nxt;
	logic          ovf;
	cell_cmd_t     cmd;
	logic [IW-1:0] roll_end;
	logic [IW-1:0] sel;
	cell_op_t      cell_op;
	logic          in_fire;
	logic          out_load;

	logic [7:0] cell_val [CAPACITY];
	logic [7:0] rd_pad   [NGRP*GRP];
	logic [7:0] grp_or   [NGRP];

	logic          valid_s1;
	logic [7:0]    grp_s1 [NGRP];
	logic [DW-1:0] depth_s1;
	logic          ovf_s1;

	logic          out_valid_q;
	logic [7:0]    read_value_q;
	logic [DW-1:0] depth_out_q;
	logic          ovf_q;
	logic [7:0]    rd_sum;

	assign out_load = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !out_load;
	assign in_fire  = in_valid && !in_stall;
	assign cell_op  = in_fire ? cmd.op : CELL_HOLD;

	bse_decode #(
		.CAPACITY (CAPACITY),
		.IW       (IW),
		.DW       (DW)
	) u_decode (
		.opcode     (opcode),
		.push_value (push_value),
		.position   (position),
		.depth      (depth_q),
		.second     (cell_val[1]),
		.cmd        (cmd),
		.roll_end   (roll_end),
		.sel        (sel),
		.depth_nxt  (depth_nxt),
		.ovf        (ovf)
	);

	for (genvar i = 0; i < NGRP*GRP; i++) begin : g_cell
		if (i < CAPACITY) begin : g_real
			logic [7:0] prev_v;
			logic [7:0] next_v;
			if (i == 0) begin : g_first
				assign prev_v = cmd.push_data;
			end else begin : g_mid_p
				assign prev_v = cell_val[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign next_v = 8'd0;
			end else begin : g_mid_n
				assign next_v = cell_val[i+1];
			end
			bse_cell #(
				.IW  (IW),
				.IDX (i)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.op       (cell_op),
				.roll_end (roll_end),
				.sel      (sel),
				.rd_en    (cmd.rd_en),
				.prev_val (prev_v),
				.next_val (next_v),
				.top_val  (cell_val[0]),
				.val      (cell_val[i]),
				.rd_val   (rd_pad[i])
			);
		end else begin : g_pad
			assign rd_pad[i] = 8'd0;
		end
	end

	// first level of the read tree, registered per group
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		always_comb begin
			grp_or[g] = 8'd0;
			for (int k = 0; k < GRP; k++)
				grp_or[g] = grp_or[g] | rd_pad[g*GRP + k];
		end
		always_ff @(posedge clk) begin
			if (in_fire)
				grp_s1[g] <= grp_or[g];
		end
	end

	always_comb begin
		rd_sum = 8'd0;
		for (int g = 0; g < NGRP; g++)
			rd_sum = rd_sum | grp_s1[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire)
				depth_q <= depth_nxt;
			if (in_fire)
				valid_s1 <= 1'b1;
			else if (out_load)
				valid_s1 <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			depth_s1 <= depth_nxt;
			ovf_s1   <= ovf;
		end
		if (out_load) begin
			read_value_q <= rd_sum;
			depth_out_q  <= depth_s1;
			ovf_q        <= ovf_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign depth      = 7'(depth_out_q);
	assign is_empty   = (depth_out_q == '0);
	assign overflowed = ovf_q;

endmodule

`default_nettype wire
